// ===== rtl/core/sft_pkg.sv =====
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types and constants of the spreadsheet formula tokenizer.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int MAX_FORMULA_LEN_DEF = 8192;
  localparam int QUEUE_DEPTH_DEF     = 8;
  localparam int MAX_TOKENS          = 4;

  localparam logic [3:0] KIND_END    = 4'd0;
  localparam logic [3:0] KIND_NUM    = 4'd1;
  localparam logic [3:0] KIND_STR    = 4'd2;
  localparam logic [3:0] KIND_BOOL   = 4'd3;
  localparam logic [3:0] KIND_ERR    = 4'd4;
  localparam logic [3:0] KIND_NAME   = 4'd5;
  localparam logic [3:0] KIND_LPAREN = 4'd6;
  localparam logic [3:0] KIND_RPAREN = 4'd7;
  localparam logic [3:0] KIND_LBRACE = 4'd8;
  localparam logic [3:0] KIND_RBRACE = 4'd9;
  localparam logic [3:0] KIND_COMMA  = 4'd10;
  localparam logic [3:0] KIND_SEMI   = 4'd11;
  localparam logic [3:0] KIND_OP     = 4'd12;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [12:0] token_start;
    logic [13:0] token_length;
    logic [7:0]  op_first;
    logic [7:0]  op_second;
    logic        is_last;
    logic        too_long;
  } tok_t;

  typedef struct packed {
    logic [2:0]                  cnt;
    tok_t [MAX_TOKENS-1:0]       tok;
  } push_t;

endpackage

// ===== rtl/core/sft_if.sv =====
// ----------------------------------------------------------------------------
// sft_if
// Valid/ready channels of the formula tokenizer.
// ----------------------------------------------------------------------------
interface sft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;
  modport source (output valid, output char_code, output final_char, input ready);
  modport sink (input valid, input char_code, input final_char, output ready);
endinterface

interface sft_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [12:0] token_start;
  logic [13:0] token_length;
  logic [7:0]  op_first;
  logic [7:0]  op_second;
  logic        is_last;
  logic        too_long;
  modport source (output valid, output token_kind, output token_start, output token_length,
                  output op_first, output op_second, output is_last, output too_long,
                  input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input op_first, input op_second, input is_last, input too_long,
                output ready);
endinterface

// ===== rtl/core/sft_lexer.sv =====
// ----------------------------------------------------------------------------
// sft_lexer
// Front end: classifies one byte per cycle while space_ok is high and pushes up to four tokens.
// ----------------------------------------------------------------------------
module sft_lexer #(
  parameter int MAX_FORMULA_LEN = 8192
) (
  input  logic            clk,
  input  logic            rst_n,
  sft_in_if.sink          in_ch,
  input  logic            space_ok,
  output sft_pkg::push_t  push
);
  import sft_pkg::*;

  localparam int PW = $clog2(MAX_FORMULA_LEN + 1);
  localparam int EW = PW + 1;
  localparam logic [PW-1:0] MAXP = PW'(MAX_FORMULA_LEN);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_NUM = 4'd1;
  localparam logic [3:0] PH_NUM_E = 4'd2;
  localparam logic [3:0] PH_DOT = 4'd3;
  localparam logic [3:0] PH_STR = 4'd4;
  localparam logic [3:0] PH_STR_Q = 4'd5;
  localparam logic [3:0] PH_SHEET = 4'd6;
  localparam logic [3:0] PH_SHEET_Q = 4'd7;
  localparam logic [3:0] PH_SHEET_TAIL = 4'd8;
  localparam logic [3:0] PH_ERR = 4'd9;
  localparam logic [3:0] PH_IDENT = 4'd10;
  localparam logic [3:0] PH_BOOL_WAIT = 4'd11;
  localparam logic [3:0] PH_CMP = 4'd12;

  localparam logic [1:0] BM_NONE = 2'd0;
  localparam logic [1:0] BM_TRUE = 2'd1;
  localparam logic [1:0] BM_FALSE = 2'd2;

  localparam logic [7:0] CH_EQ = "=";
  localparam logic [7:0] CH_HASH = "#";
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_BANG = "!";
  localparam logic [7:0] CH_QMARK = "?";
  localparam logic [7:0] CH_DQ = "\"";
  localparam logic [7:0] CH_SQ = "'";
  localparam logic [7:0] CH_DOT = ".";
  localparam logic [7:0] CH_PLUS = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_LT = "<";
  localparam logic [7:0] CH_GT = ">";
  localparam logic [7:0] CH_LP = "(";
  localparam logic [7:0] CH_RP = ")";
  localparam logic [7:0] CH_LB = "{";
  localparam logic [7:0] CH_RB = "}";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_SEMI = ";";
  localparam logic [7:0] CH_SP = " ";
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_US = "_";
  localparam logic [7:0] CH_UE = "E";
  localparam logic [7:0] CH_LE = "e";
  localparam logic [7:0] CH_UT = "T";
  localparam logic [7:0] CH_UF = "F";

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic id_start(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_US || c == CH_DOLLAR;
  endfunction

  function automatic logic id_cont(input logic [7:0] c);
    return id_start(c) || is_dig(c) || c == CH_DOT || c == CH_BANG;
  endfunction

  function automatic logic [7:0] word_ch(input logic is_false, input logic [2:0] k);
    logic [7:0] r;
    r = 8'h00;
    if (is_false) begin
      case (k)
        3'd0: r = "F";
        3'd1: r = "A";
        3'd2: r = "L";
        3'd3: r = "S";
        3'd4: r = "E";
        default: r = 8'h00;
      endcase
    end else begin
      case (k)
        3'd0: r = "T";
        3'd1: r = "R";
        3'd2: r = "U";
        3'd3: r = "E";
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic tok_t make_tok(input logic [3:0] kind, input logic [EW-1:0] s,
                                    input logic [EW-1:0] e, input logic [7:0] o1,
                                    input logic [7:0] o2, input logic last,
                                    input logic ovf);
    tok_t t;
    logic [31:0] s32;
    logic [31:0] l32;
    s32 = 32'(s);
    l32 = (e > s) ? 32'(e - s) : 32'd0;
    t.token_kind = kind;
    t.token_start = (s32 > 32'd8191) ? 13'd8191 : s32[12:0];
    t.token_length = (l32 > 32'd8192) ? 14'd8192 : l32[13:0];
    t.op_first = o1;
    t.op_second = o2;
    t.is_last = last;
    t.too_long = ovf;
    return t;
  endfunction

  logic [3:0]    ph_r, ph_nxt;
  logic [PW-1:0] org_r, org_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          dot_r, dot_nxt;
  logic [1:0]    bm_r, bm_nxt;
  logic          fb_r, fb_nxt;
  logic [7:0]    pop_r, pop_nxt;
  logic          ovf_r, ovf_nxt;
  tok_t [MAX_TOKENS-1:0] toks;
  logic [2:0]    n;
  logic          acc;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = space_ok;

  always_comb begin
    logic [7:0]    b;
    logic          skip;
    logic          go;
    logic          em;
    logic [3:0]    ek;
    logic [EW-1:0] es, ee;
    logic [7:0]    eo1, eo2;
    logic [PW-1:0] nxtp, epos, k;
    logic [EW-1:0] wl;
    b = in_ch.char_code;
    ph_nxt = ph_r;
    org_nxt = org_r;
    pos_nxt = pos_r;
    dot_nxt = dot_r;
    bm_nxt = bm_r;
    fb_nxt = fb_r;
    pop_nxt = pop_r;
    ovf_nxt = ovf_r;
    toks = '0;
    n = 3'd0;
    skip = 1'b0;
    go = 1'b0;
    em = 1'b0;
    ek = KIND_END;
    es = '0;
    ee = '0;
    eo1 = '0;
    eo2 = '0;
    nxtp = '0;
    epos = '0;
    k = '0;
    wl = '0;
    if (fb_r) begin
      fb_nxt = 1'b0;
      skip = (b == CH_EQ);
    end
    if (!skip) begin
      if (pos_nxt >= MAXP) begin
        ovf_nxt = 1'b1;
        pos_nxt = MAXP;
      end
      nxtp = (pos_nxt < MAXP) ? pos_nxt + 1'b1 : MAXP;
      go = 1'b1;
      for (int it = 0; it < 4; it++) begin
        em = 1'b0;
        ek = KIND_END;
        es = EW'(org_nxt);
        ee = EW'(pos_nxt);
        eo1 = '0;
        eo2 = '0;
        wl = (bm_nxt == BM_TRUE) ? EW'(4) : EW'(5);
        if (go) begin
          go = 1'b0;
          case (ph_nxt)
            PH_NUM: begin
              if (is_dig(b)) begin
              end else if (b == CH_DOT && !dot_nxt) begin
                dot_nxt = 1'b1;
              end else if (b == CH_LE || b == CH_UE) begin
                ph_nxt = PH_NUM_E;
              end else begin
                em = 1'b1; ek = KIND_NUM; ph_nxt = PH_IDLE; go = 1'b1;
              end
            end
            PH_NUM_E: begin
              if (b == CH_PLUS || b == CH_MINUS || is_dig(b)) begin
                ph_nxt = PH_NUM;
              end else begin
                epos = (pos_nxt > org_nxt) ? pos_nxt - 1'b1 : org_nxt;
                em = 1'b1; ek = KIND_NUM; ee = EW'(epos);
                org_nxt = epos; bm_nxt = BM_NONE; ph_nxt = PH_IDENT; go = 1'b1;
              end
            end
            PH_DOT: begin
              if (is_dig(b)) begin
                ph_nxt = PH_NUM; dot_nxt = 1'b1;
              end else begin
                em = 1'b1; ek = KIND_OP; ee = EW'(org_nxt) + 1'b1; eo1 = CH_DOT;
                ph_nxt = PH_IDLE; go = 1'b1;
              end
            end
            PH_STR: begin
              if (b == CH_DQ) ph_nxt = PH_STR_Q;
            end
            PH_STR_Q: begin
              if (b == CH_DQ) begin
                ph_nxt = PH_STR;
              end else begin
                em = 1'b1; ek = KIND_STR; ph_nxt = PH_IDLE; go = 1'b1;
              end
            end
            PH_SHEET: begin
              if (b == CH_SQ) ph_nxt = PH_SHEET_Q;
            end
            PH_SHEET_Q: begin
              if (b == CH_SQ) begin
                ph_nxt = PH_SHEET;
              end else if (b == CH_BANG) begin
                ph_nxt = PH_SHEET_TAIL;
              end else begin
                em = 1'b1; ek = KIND_NAME; ph_nxt = PH_IDLE; go = 1'b1;
              end
            end
            PH_SHEET_TAIL: begin
              if (!id_cont(b)) begin
                em = 1'b1; ek = KIND_NAME; ph_nxt = PH_IDLE; go = 1'b1;
              end
            end
            PH_ERR: begin
              if (b == CH_BANG || b == CH_QMARK) begin
                em = 1'b1; ek = KIND_ERR; ee = EW'(nxtp); ph_nxt = PH_IDLE;
              end else if (b == CH_COMMA || b == CH_RP || b == CH_SP || b == CH_TAB) begin
                em = 1'b1; ek = KIND_ERR; ph_nxt = PH_IDLE; go = 1'b1;
              end
            end
            PH_IDENT: begin
              k = (pos_nxt > org_nxt) ? pos_nxt - org_nxt : '0;
              if (id_cont(b)) begin
                if (bm_nxt == BM_TRUE) begin
                  if (k >= PW'(4) || (b & 8'hdf) != word_ch(1'b0, k[2:0])) bm_nxt = BM_NONE;
                end else if (bm_nxt == BM_FALSE) begin
                  if (k >= PW'(5) || (b & 8'hdf) != word_ch(1'b1, k[2:0])) bm_nxt = BM_NONE;
                end
              end else if (bm_nxt != BM_NONE && EW'(k) == wl) begin
                ph_nxt = PH_BOOL_WAIT; go = 1'b1;
              end else begin
                em = 1'b1; ek = KIND_NAME; ph_nxt = PH_IDLE; go = 1'b1;
              end
            end
            PH_BOOL_WAIT: begin
              if (!is_ws(b)) begin
                em = 1'b1; ek = (b == CH_LP) ? KIND_NAME : KIND_BOOL;
                ee = EW'(org_nxt) + wl;
                bm_nxt = BM_NONE; ph_nxt = PH_IDLE; go = 1'b1;
              end
            end
            PH_CMP: begin
              em = 1'b1; ek = KIND_OP; eo1 = pop_nxt; ph_nxt = PH_IDLE;
              if (b == CH_EQ || (pop_nxt == CH_LT && b == CH_GT)) begin
                ee = EW'(nxtp); eo2 = b;
              end else begin
                ee = EW'(org_nxt) + 1'b1; go = 1'b1;
              end
              pop_nxt = '0;
            end
            default: begin
              ph_nxt = PH_IDLE;
              org_nxt = pos_nxt;
              es = EW'(pos_nxt);
              ee = EW'(nxtp);
              if (!is_ws(b)) begin
                case (b)
                  CH_LP: begin em = 1'b1; ek = KIND_LPAREN; end
                  CH_RP: begin em = 1'b1; ek = KIND_RPAREN; end
                  CH_LB: begin em = 1'b1; ek = KIND_LBRACE; end
                  CH_RB: begin em = 1'b1; ek = KIND_RBRACE; end
                  CH_COMMA: begin em = 1'b1; ek = KIND_COMMA; end
                  CH_SEMI: begin em = 1'b1; ek = KIND_SEMI; end
                  CH_DQ: ph_nxt = PH_STR;
                  CH_HASH: ph_nxt = PH_ERR;
                  CH_DOT: ph_nxt = PH_DOT;
                  CH_SQ: ph_nxt = PH_SHEET;
                  CH_LT, CH_GT: begin pop_nxt = b; ph_nxt = PH_CMP; end
                  default: begin
                    if (is_dig(b)) begin
                      dot_nxt = 1'b0; ph_nxt = PH_NUM;
                    end else if (id_start(b)) begin
                      bm_nxt = ((b & 8'hdf) == CH_UT) ? BM_TRUE :
                               (((b & 8'hdf) == CH_UF) ? BM_FALSE : BM_NONE);
                      ph_nxt = PH_IDENT;
                    end else begin
                      em = 1'b1; ek = KIND_OP; eo1 = b;
                    end
                  end
                endcase
              end
            end
          endcase
        end
        if (em && n < 3'd4) begin
          toks[n[1:0]] = make_tok(ek, es, ee, eo1, eo2, 1'b0, ovf_nxt);
          n = n + 3'd1;
        end
      end
      if (pos_nxt < MAXP) pos_nxt = pos_nxt + 1'b1;
    end
    if (in_ch.final_char) begin
      em = 1'b1;
      ek = KIND_END;
      es = EW'(org_nxt);
      ee = EW'(pos_nxt);
      eo1 = '0;
      wl = (bm_nxt == BM_TRUE) ? EW'(4) : EW'(5);
      epos = (pos_nxt > org_nxt) ? pos_nxt - 1'b1 : org_nxt;
      k = (pos_nxt > org_nxt) ? pos_nxt - org_nxt : '0;
      case (ph_nxt)
        PH_NUM: ek = KIND_NUM;
        PH_NUM_E: begin ek = KIND_NUM; ee = EW'(epos); end
        PH_DOT: begin ek = KIND_OP; ee = EW'(org_nxt) + 1'b1; eo1 = CH_DOT; end
        PH_STR, PH_STR_Q: ek = KIND_STR;
        PH_SHEET, PH_SHEET_Q, PH_SHEET_TAIL: ek = KIND_NAME;
        PH_ERR: ek = KIND_ERR;
        PH_IDENT: ek = (bm_nxt != BM_NONE && EW'(k) == wl) ? KIND_BOOL : KIND_NAME;
        PH_BOOL_WAIT: begin ek = KIND_BOOL; ee = EW'(org_nxt) + wl; end
        PH_CMP: begin ek = KIND_OP; ee = EW'(org_nxt) + 1'b1; eo1 = pop_nxt; end
        default: em = 1'b0;
      endcase
      if (em && n < 3'd4) begin
        toks[n[1:0]] = make_tok(ek, es, ee, eo1, 8'h00, 1'b0, ovf_nxt);
        n = n + 3'd1;
      end
      if (ph_nxt == PH_NUM_E && n < 3'd4) begin
        toks[n[1:0]] = make_tok(KIND_NAME, EW'(epos), EW'(pos_nxt), 8'h00, 8'h00, 1'b0,
                                ovf_nxt);
        n = n + 3'd1;
      end
      if (n < 3'd4) begin
        toks[n[1:0]] = make_tok(KIND_END, EW'(pos_nxt), EW'(pos_nxt), 8'h00, 8'h00, 1'b1,
                                ovf_nxt);
        n = n + 3'd1;
      end
      ph_nxt = PH_IDLE;
      org_nxt = '0;
      pos_nxt = '0;
      dot_nxt = 1'b0;
      bm_nxt = BM_NONE;
      fb_nxt = 1'b1;
      pop_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      org_r <= '0;
      pos_r <= '0;
      dot_r <= 1'b0;
      bm_r <= BM_NONE;
      fb_r <= 1'b1;
      pop_r <= '0;
      ovf_r <= 1'b0;
    end else if (acc) begin
      ph_r <= ph_nxt;
      org_r <= org_nxt;
      pos_r <= pos_nxt;
      dot_r <= dot_nxt;
      bm_r <= bm_nxt;
      fb_r <= fb_nxt;
      pop_r <= pop_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign push.cnt = acc ? n : 3'd0;
  assign push.tok = toks;

  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.final_char) |=> (pos_r == '0 && fb_r && ph_r == PH_IDLE && !ovf_r))
    else $error("state not cleared after final byte");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= MAXP)
    else $error("byte position beyond limit");
  a_last_push: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.final_char) |-> push.cnt != 3'd0)
    else $error("final byte pushed no end token");
endmodule

// ===== rtl/core/sft_queue.sv =====
// ----------------------------------------------------------------------------
// sft_queue
// Back end: token queue filled up to four per cycle, drained one per cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module sft_queue #(
  parameter int DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sft_pkg::push_t push,
  output logic           space_ok,
  sft_out_if.source      out_ch
);
  import sft_pkg::*;

  localparam int AW = $clog2(DEPTH);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;
  tok_t          head;

  assign pop = out_ch.valid && out_ch.ready;
  assign space_ok = cnt_r <= (AW+1)'(DEPTH - MAX_TOKENS);
  assign head = mem[rd_r];

  assign wr_nxt = wr_r + AW'(push.cnt);
  assign rd_nxt = pop ? rd_r + 1'b1 : rd_r;
  assign cnt_nxt = cnt_r + (AW+1)'(push.cnt) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (3'(i) < push.cnt) mem[wr_r + AW'(i)] <= push.tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid = cnt_r != '0;
  assign out_ch.token_kind = head.token_kind;
  assign out_ch.token_start = head.token_start;
  assign out_ch.token_length = head.token_length;
  assign out_ch.op_first = head.op_first;
  assign out_ch.op_second = head.op_second;
  assign out_ch.is_last = head.is_last;
  assign out_ch.too_long = head.too_long;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 3'd0) |-> space_ok)
    else $error("push without room");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r == $past(cnt_r) + (AW+1)'($past(push.cnt)) - (AW+1)'($past(pop)))
    else $error("queue count out of step");
endmodule

// ===== rtl/core/spreadsheet_formula_tokenizer.sv =====
// a token is written into the queue as the byte that completes it is accepted
// throughput: one byte per cycle while the queue has room for four tokens
// results leave one per cycle from the queue head while the sink is ready; a byte yields up to four
// synchronous active-low reset returns the lexer to its start-of-formula state
// and empties the queue
// ----------------------------------------------------------------------------
// spreadsheet_formula_tokenizer
// Streaming lexer for spreadsheet formulas, one byte in, tokens out.
// ----------------------------------------------------------------------------
module spreadsheet_formula_tokenizer #(
  parameter int MAX_FORMULA_LEN = sft_pkg::MAX_FORMULA_LEN_DEF,
  parameter int QUEUE_DEPTH     = sft_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sft_in_if.sink     in_ch,
  sft_out_if.source  out_ch
);
  import sft_pkg::*;

  push_t push;
  logic  space_ok;

  sft_lexer #(.MAX_FORMULA_LEN(MAX_FORMULA_LEN)) u_lexer (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .space_ok(space_ok), .push(push)
  );

  sft_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .space_ok(space_ok), .out_ch(out_ch)
  );
endmodule
